// ===== src/sobel_edge_magnitude_unit_assert.svh =====
// Assertion macros for the Sobel edge magnitude unit.
`ifndef SOBEL_EDGE_MAGNITUDE_UNIT_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define SEM_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SEM_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);
`else
`define SEM_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define SEM_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg)
`endif
`endif

// ===== src/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared constants and the front-to-back job record.
// ----------------------------------------------------------------------------
package sem_pkg;
    localparam int MaxWidthDefault  = 1024;
    localparam int MaxHeightDefault = 4096;
    localparam int CfgIdxWidth = 1;
    localparam int CfgDataWidth = 13;
    localparam logic [0:0] RegImageWidth  = 1'b0;
    localparam logic [0:0] RegImageHeight = 1'b1;
    localparam int SumWidth = 10;
    localparam int GradWidth = 13;

    // One job: up to three results to emit for one input pixel.
    typedef struct packed {
        logic        emit_main;   // pixel (y-1,x-1)
        logic        interior;    // main pixel needs a gradient
        logic        emit_edge;   // black (y-1,W-1)
        logic        emit_low;    // black (y,x)
        logic [11:0] row;
        logic [9:0]  col;
        logic [9:0]  last_col;
        logic signed [GradWidth-1:0] gx;
        logic signed [GradWidth-1:0] gy;
    } job_t;
endpackage

// ===== src/sem_stream_if.sv =====
// ----------------------------------------------------------------------------
// Sobel stream interfaces
// Pixel, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface sem_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface sem_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic [7:0]  gray;
    logic        last;
    modport source (output valid, out_row, out_col, gray, last, input ready);
    modport sink   (input valid, out_row, out_col, gray, last, output ready);
endinterface

interface sem_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [sem_pkg::CfgIdxWidth-1:0]     index;
    logic [sem_pkg::CfgDataWidth-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/sem_front.sv =====
// ----------------------------------------------------------------------------
// Sobel front end
// Position tracking, line buffers, window and gradients; emits one job a beat unless job_ready stalls it.
// ----------------------------------------------------------------------------
module sem_front #(
    parameter int MAX_WIDTH  = sem_pkg::MaxWidthDefault,
    parameter int MAX_HEIGHT = sem_pkg::MaxHeightDefault
) (
    input  logic          clk,
    input  logic          rst_n,
    sem_pixel_if.sink     pix,
    input  logic [10:0]   image_width,
    input  logic [12:0]   image_height,
    output logic          job_valid,
    output sem_pkg::job_t job,
    input  logic          job_ready
);
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SW = sem_pkg::SumWidth;
    localparam int GW = sem_pkg::GradWidth;

    // Two-stage: stage A reads line buffers, stage B forms gradients.
    logic [SW-1:0] older_mem [MAX_WIDTH];
    logic [SW-1:0] prior_mem [MAX_WIDTH];
    logic [SW-1:0] top_rd_reg, mid_rd_reg;

    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;
    logic [SW-1:0] win_reg [6];

    logic          a_valid_reg;
    logic [SW-1:0] a_sum_reg;
    logic [XW-1:0] a_x_reg;
    logic [YW-1:0] a_y_reg;
    logic          a_lc_reg, a_lr_reg, a_in_reg;
    logic [12:0]   a_w_reg;

    logic          job_valid_reg;
    sem_pkg::job_t job_reg;

    logic [12:0] w_eff, h_eff;
    logic [12:0] x_ext;
    logic [16:0] y_ext;
    logic        last_col, last_row, interior;
    logic        a_ready, pix_fire, a_fire;
    logic [SW-1:0] sum_in;

    always_comb
    begin
        w_eff = (image_width == 11'd0) ? 13'd1 :
                ({2'b0, image_width} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) :
                {2'b0, image_width};
        h_eff = (image_height == 13'd0) ? 13'd1 :
                ({4'b0, image_height} > 17'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : image_height;
        x_ext = 13'(col_reg);
        y_ext = 17'(row_reg);
        last_col = (x_ext + 13'd1) >= w_eff;
        last_row = (y_ext + 17'd1) >= {4'b0, h_eff};
        interior = (y_ext >= 17'd2) && (x_ext >= 13'd2) &&
                   (y_ext < {4'b0, h_eff}) && (x_ext < w_eff);
        sum_in = SW'(pix.red) + SW'(pix.green) + SW'(pix.blue);
    end

    // A job slot is free when stage B empties or will empty this beat.
    assign a_ready  = !job_valid_reg || job_ready;
    assign a_fire   = a_valid_reg && a_ready;
    assign pix.ready = !a_valid_reg || a_ready;
    assign pix_fire = pix.valid && pix.ready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (pix_fire)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : YW'(y_ext + 17'd1);
            end
            else
            begin
                col_next = XW'(x_ext + 13'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            top_rd_reg <= older_mem[col_reg];
            mid_rd_reg <= prior_mem[col_reg];
            older_mem[col_reg] <= prior_mem[col_reg];
            prior_mem[col_reg] <= sum_in;
            a_sum_reg <= sum_in;
            a_x_reg   <= col_reg;
            a_y_reg   <= row_reg;
            a_lc_reg  <= last_col;
            a_lr_reg  <= last_row;
            a_in_reg  <= interior;
            a_w_reg   <= w_eff;
        end
    end

    logic signed [GW-1:0] tl, cl, bl, tc, bc, tr, cr, br, gx, gy;
    always_comb
    begin
        tl = GW'(win_reg[0]); cl = GW'(win_reg[1]); bl = GW'(win_reg[2]);
        tc = GW'(win_reg[3]); bc = GW'(win_reg[5]);
        tr = GW'(top_rd_reg); cr = GW'(mid_rd_reg); br = GW'(a_sum_reg);
        gx = bl + (bc <<< 1) + br - tl - (tc <<< 1) - tr;
        gy = tr + (cr <<< 1) + br - tl - (cl <<< 1) - bl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            a_valid_reg <= 1'b0;
            job_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++) win_reg[i] <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (pix_fire)
                a_valid_reg <= 1'b1;
            else if (a_fire)
                a_valid_reg <= 1'b0;
            if (a_fire)
            begin
                job_valid_reg <= 1'b1;
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top_rd_reg;
                win_reg[4] <= mid_rd_reg;
                win_reg[5] <= a_sum_reg;
            end
            else if (job_ready)
            begin
                job_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            job_reg.emit_main <= (a_y_reg != '0) && (a_x_reg != '0);
            job_reg.interior  <= a_in_reg;
            job_reg.emit_edge <= (a_y_reg != '0) && a_lc_reg;
            job_reg.emit_low  <= a_lr_reg;
            job_reg.row       <= 12'(a_y_reg);
            job_reg.col       <= 10'(a_x_reg);
            job_reg.last_col  <= 10'(a_w_reg - 13'd1);
            job_reg.gx        <= gx;
            job_reg.gy        <= gy;
        end
    end

    assign job_valid = job_valid_reg;
    assign job = job_reg;
endmodule

// ===== src/sem_fifo.sv =====
// ----------------------------------------------------------------------------
// Sobel job queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sem_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sem_pkg::job_t in_job,
    output logic          out_valid,
    input  logic          out_ready,
    output sem_pkg::job_t out_job
);
    sem_pkg::job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_job   = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= in_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

// ===== src/sem_back.sv =====
// ----------------------------------------------------------------------------
// Sobel back end
// Squares gradients, runs a bit-serial square root, emits results.
// ----------------------------------------------------------------------------
module sem_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  sem_pkg::job_t  job,
    sem_result_if.source   res
);
    typedef enum logic [2:0] {ST_IDLE, ST_SQ, ST_ROOT, ST_MAIN, ST_EDGE, ST_LOW} state_t;

    state_t        state_reg;
    sem_pkg::job_t job_reg;
    logic [24:0]   gx2_reg, gy2_reg;
    logic [7:0]    root_reg;
    logic [2:0]    bit_reg;
    logic [11:0]   row_reg;
    logic [9:0]    col_reg;
    logic [7:0]    gray_reg;
    logic          last_reg;
    logic          valid_reg;

    logic [25:0] ssum;
    logic [7:0]  trial;
    logic [15:0] trial_sq;
    logic        more_edge, more_low;
    logic        out_free;

    assign ssum     = {1'b0, gx2_reg} + {1'b0, gy2_reg};
    assign trial    = root_reg | (8'd1 << bit_reg);
    assign trial_sq = trial * trial;
    assign out_free = !valid_reg || res.ready;
    assign job_ready = (state_reg == ST_IDLE);
    assign more_edge = job_reg.emit_edge;
    assign more_low  = job_reg.emit_low;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (valid_reg && res.ready) valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg <= job;
                        if (job.emit_main && job.interior)
                            state_reg <= ST_SQ;
                        else if (job.emit_main)
                        begin
                            root_reg <= 8'd0;
                            state_reg <= ST_MAIN;
                        end
                        else if (job.emit_edge)
                            state_reg <= ST_EDGE;
                        else if (job.emit_low)
                            state_reg <= ST_LOW;
                    end
                end
                ST_SQ:
                begin
                    gx2_reg <= 25'(job_reg.gx * job_reg.gx);
                    gy2_reg <= 25'(job_reg.gy * job_reg.gy);
                    root_reg <= 8'd0;
                    bit_reg <= 3'd7;
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    if ({10'd0, trial_sq} <= ssum) root_reg <= trial;
                    bit_reg <= bit_reg - 3'd1;
                    if (bit_reg == 3'd0)
                    begin
                        if (ssum >= 26'd65536) root_reg <= 8'd255;
                        state_reg <= ST_MAIN;
                    end
                end
                ST_MAIN:
                begin
                    if (out_free)
                    begin
                        valid_reg <= 1'b1;
                        row_reg <= job_reg.row - 12'd1;
                        col_reg <= job_reg.col - 10'd1;
                        gray_reg <= job_reg.interior ? root_reg : 8'd0;
                        last_reg <= !(more_edge || more_low);
                        state_reg <= more_edge ? ST_EDGE : more_low ? ST_LOW : ST_IDLE;
                    end
                end
                ST_EDGE:
                begin
                    if (out_free)
                    begin
                        valid_reg <= 1'b1;
                        row_reg <= job_reg.row - 12'd1;
                        col_reg <= job_reg.last_col;
                        gray_reg <= 8'd0;
                        last_reg <= !more_low;
                        state_reg <= more_low ? ST_LOW : ST_IDLE;
                    end
                end
                ST_LOW:
                begin
                    if (out_free)
                    begin
                        valid_reg <= 1'b1;
                        row_reg <= job_reg.row;
                        col_reg <= job_reg.col;
                        gray_reg <= 8'd0;
                        last_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign res.valid   = valid_reg;
    assign res.out_row = row_reg;
    assign res.out_col = col_reg;
    assign res.gray    = gray_reg;
    assign res.last    = last_reg;
endmodule

// ===== src/sobel_edge_magnitude_unit.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit
// Streaming 3x3 Sobel edge detector on R+G+B intensity.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// pix      in   red, green, blue
// res      out  out_row, out_col, gray, last
// cfg      in   index, data (0 = image_width, 1 = image_height)
// An interior pixel holds the back end through accept, square, eight root
// steps and emit, plus one emit step per extra black result; other pixels
// skip the square and root steps. The serial square root is the longest part.
// The front end takes a pixel every beat while the two-entry queue has room.
// A stalled result holds the back end in its emit state until it is taken.
// Reset clears position and window; line buffers hold no reset value.
`include "sobel_edge_magnitude_unit_assert.svh"
module sobel_edge_magnitude_unit #(
    parameter int MAX_WIDTH  = sem_pkg::MaxWidthDefault,
    parameter int MAX_HEIGHT = sem_pkg::MaxHeightDefault
) (
    input  logic          clk,
    input  logic          rst_n,
    sem_pixel_if.sink     pix,
    sem_result_if.source  res,
    sem_cfg_if.sink       cfg
);
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic f_valid, f_ready, q_valid, q_ready;
    logic res_row0;
    sem_pkg::job_t f_job, q_job;

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1024;
            height_reg <= 13'd4096;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                sem_pkg::RegImageWidth:  width_reg  <= cfg.data[10:0];
                sem_pkg::RegImageHeight: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk(clk), .rst_n(rst_n), .pix(pix),
        .image_width(width_reg), .image_height(height_reg),
        .job_valid(f_valid), .job(f_job), .job_ready(f_ready)
    );

    sem_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
        .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
    );

    sem_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job), .res(res)
    );

    assign res_row0 = res.valid && (res.out_row == 12'd0);

    `SEM_ASSERT_NEXT(a_res_hold, clk, rst_n, res.valid && !res.ready, res.valid, "result dropped")
    `SEM_ASSERT_IMPL(a_gray_border, clk, rst_n, res_row0 |-> (res.gray == 8'd0), "row 0 lit")
endmodule
